>>> rtl/json_string_unescaper_unit_macros.svh
// Assertion macros shared by the string unescaper modules.
// Users must have clk and arst_n in scope.
`ifndef JSON_STRING_UNESCAPER_UNIT_MACROS_SVH
`define JSON_STRING_UNESCAPER_UNIT_MACROS_SVH

// Implication checked in the same cycle.
`define JSU_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the following cycle.
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/jsu_pkg.sv
`timescale 1ns / 1ps
// Types and fixed sizes shared by the string unescaper modules.
// No dependencies.
package jsu_pkg;

	localparam int ByteW       = 8;
	localparam int ResultSlots = 4;
	localparam int CountW      = 3;
	localparam int SlotIdxW    = 2;

	typedef struct packed {
		logic [ByteW-1:0] data_byte;
		logic             byte_valid;
		logic             string_done;
		logic             syntax_error;
	} result_t;

	// All results caused by one text item, in delivery order.
	typedef struct packed {
		result_t [ResultSlots-1:0] res;
		logic [CountW-1:0]         count;
	} bundle_t;

endpackage

>>> rtl/jsu_text_if.sv
`timescale 1ns / 1ps
// Text byte channel: valid/ready handshake with the raw JSON byte.
// Depends on jsu_pkg.
interface jsu_text_if;
	import jsu_pkg::*;

	logic             valid;
	logic             ready;
	logic [ByteW-1:0] text_byte;
	logic             text_ends;

	modport source (output valid, text_byte, text_ends, input ready);
	modport sink (input valid, text_byte, text_ends, output ready);
endinterface

>>> rtl/jsu_result_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with one decoded result.
// Depends on jsu_pkg.
interface jsu_result_if;
	import jsu_pkg::*;

	logic             valid;
	logic             ready;
	logic [ByteW-1:0] data_byte;
	logic             byte_valid;
	logic             string_done;
	logic             syntax_error;

	modport source (output valid, data_byte, byte_valid, string_done, syntax_error,
		input ready);
	modport sink (input valid, data_byte, byte_valid, string_done, syntax_error,
		output ready);
endinterface

>>> rtl/jsu_decoder.sv
`timescale 1ns / 1ps
// Input register, parser state and the single-pass decode of one text byte
// into a bundle of up to four results. Depends on jsu_pkg, jsu_text_if, the macro file.
`include "json_string_unescaper_unit_macros.svh"

module jsu_decoder (
	input  logic             clk,
	input  logic             arst_n,
	jsu_text_if.sink         text,
	output jsu_pkg::bundle_t bundle,
	output logic             bundle_valid,
	input  logic             bundle_ready
);
	import jsu_pkg::*;

	typedef enum logic [1:0] {PH_IDLE, PH_STR, PH_ESC, PH_HEX} phase_t;

	localparam logic [7:0] ChQuote = 8'h22;
	localparam logic [7:0] ChBslash = 8'h5C;
	localparam logic [7:0] ChN = 8'h6E;
	localparam logic [7:0] ChR = 8'h72;
	localparam logic [7:0] ChT = 8'h74;
	localparam logic [7:0] ChB = 8'h62;
	localparam logic [7:0] ChF = 8'h66;
	localparam logic [7:0] ChU = 8'h75;
	localparam logic [7:0] Cont = 8'h80;
	localparam logic [7:0] Lead2 = 8'hC0;
	localparam logic [7:0] Lead3 = 8'hE0;
	localparam logic [7:0] Lead4 = 8'hF0;
	localparam logic [15:0] Lim1 = 16'h0080;
	localparam logic [15:0] Lim2 = 16'h0800;

	typedef struct packed {
		logic [CountW-1:0]  len;
		logic [2:0][7:0]    b;
	} enc_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
		else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
		else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
		return v;
	endfunction

	function automatic logic [1:0] lead_len(input logic [7:0] c);
		logic [1:0] n;
		n = 2'd0;
		if (c >= Lead4) n = 2'd3;
		else if (c >= Lead3) n = 2'd2;
		else if (c >= Lead2) n = 2'd1;
		return n;
	endfunction

	// UTF-8 encoding of a 16-bit code point; the low six bits of each
	// continuation byte come straight from the code.
	function automatic enc_t encode(input logic [15:0] cp);
		enc_t e;
		e = '0;
		if (cp < Lim1) begin
			e.len  = CountW'(1);
			e.b[0] = cp[7:0];
		end else if (cp < Lim2) begin
			e.len  = CountW'(2);
			e.b[0] = Lead2 | {3'b000, cp[10:6]};
			e.b[1] = Cont | {2'b00, cp[5:0]};
		end else begin
			e.len  = CountW'(3);
			e.b[0] = Lead3 | {4'b0000, cp[15:12]};
			e.b[1] = Cont | {2'b00, cp[11:6]};
			e.b[2] = Cont | {2'b00, cp[5:0]};
		end
		return e;
	endfunction

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             ends_s1;
	phase_t           phase_q, phase_d;
	logic [1:0]       raw_q, raw_d;
	logic [1:0]       hex_q, hex_d;
	logic [15:0]      code_q, code_d, code_shift;
	logic             step;
	logic [CountW-1:0] byte_cnt;
	logic [3:0][7:0]  bytes;
	logic             tail, tail_err, enc_en;
	logic [15:0]      enc_cp;
	enc_t             enc;

	assign step         = valid_s1 && bundle_ready;
	assign text.ready   = !valid_s1 || bundle_ready;
	assign bundle_valid = valid_s1;
	assign code_shift   = {code_q[11:0], hex_value(byte_s1)};

	always_comb begin
		phase_d  = phase_q;
		raw_d    = raw_q;
		hex_d    = hex_q;
		code_d   = code_q;
		byte_cnt = '0;
		bytes    = '0;
		tail     = 1'b0;
		tail_err = 1'b0;
		enc_en   = 1'b0;
		enc_cp   = code_q;
		unique case (phase_q)
			PH_IDLE: begin
				if (byte_s1 == ChQuote) begin
					phase_d = PH_STR;
					raw_d   = 2'd0;
				end else if (!is_space(byte_s1) || ends_s1) begin
					tail     = 1'b1;
					tail_err = 1'b1;
				end
			end
			PH_STR: begin
				if (raw_q != 2'd0) begin
					raw_d    = raw_q - 2'd1;
					byte_cnt = CountW'(1);
					bytes[0] = byte_s1;
				end else if (byte_s1 == ChQuote) begin
					tail    = 1'b1;
					phase_d = PH_IDLE;
				end else if (byte_s1 == ChBslash) begin
					phase_d = PH_ESC;
				end else begin
					raw_d    = lead_len(byte_s1);
					byte_cnt = CountW'(1);
					bytes[0] = byte_s1;
				end
			end
			PH_ESC: begin
				phase_d  = PH_STR;
				byte_cnt = CountW'(1);
				unique case (byte_s1)
					ChN: bytes[0] = 8'h0A;
					ChR: bytes[0] = 8'h0D;
					ChT: bytes[0] = 8'h09;
					ChB: bytes[0] = 8'h08;
					ChF: bytes[0] = 8'h0C;
					ChU: begin
						phase_d  = PH_HEX;
						hex_d    = 2'd0;
						code_d   = '0;
						byte_cnt = '0;
					end
					default: bytes[0] = byte_s1;
				endcase
			end
			PH_HEX: begin
				code_d = code_shift;
				hex_d  = hex_q + 2'd1;
				if (hex_q == 2'd3) begin
					enc_en  = 1'b1;
					enc_cp  = code_shift;
					phase_d = PH_STR;
					hex_d   = 2'd0;
					code_d  = '0;
				end
			end
			default: phase_d = PH_IDLE;
		endcase

		// End of text inside a string flushes any partial escape and closes it.
		if (ends_s1 && phase_d != PH_IDLE) begin
			if (phase_d == PH_HEX) begin
				enc_en = 1'b1;
				enc_cp = code_d;
			end
			tail    = 1'b1;
			phase_d = PH_IDLE;
			hex_d   = 2'd0;
			code_d  = '0;
			raw_d   = 2'd0;
		end

		enc = encode(enc_cp);
		if (enc_en) begin
			byte_cnt = enc.len;
			bytes    = {8'h00, enc.b};
		end
	end

	always_comb begin
		bundle.count = byte_cnt + CountW'(tail);
		for (int i = 0; i < ResultSlots; i++) begin
			if (CountW'(i) < byte_cnt) begin
				bundle.res[i] = '{data_byte: bytes[i], byte_valid: 1'b1,
					string_done: 1'b0, syntax_error: 1'b0};
			end else if (CountW'(i) == byte_cnt && tail) begin
				bundle.res[i] = '{data_byte: 8'h00, byte_valid: 1'b0,
					string_done: 1'b1, syntax_error: tail_err};
			end else begin
				bundle.res[i] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= PH_IDLE;
			raw_q    <= 2'd0;
			hex_q    <= 2'd0;
			code_q   <= '0;
		end else begin
			if (text.ready) valid_s1 <= text.valid;
			if (step) begin
				phase_q <= phase_d;
				raw_q   <= raw_d;
				hex_q   <= hex_d;
				code_q  <= code_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1 <= text.text_byte;
			ends_s1 <= text.text_ends;
		end
	end

	`JSU_ASSERT_IMPL(a_count_fits, bundle_valid, bundle.count <= CountW'(ResultSlots),
		"decoder produced more results than slots")
	`JSU_ASSERT_IMPL(a_error_alone, bundle_valid && bundle.res[0].syntax_error,
		bundle.count == CountW'(1), "error item must give exactly one result")
	`JSU_ASSERT_NEXT(a_end_idle, step && ends_s1, phase_q == PH_IDLE,
		"parser not idle after end of text")
	`JSU_ASSERT_IMPL(a_raw_in_string, raw_q != 2'd0, phase_q == PH_STR,
		"raw continuation count outside a string")
	`JSU_ASSERT_IMPL(a_hex_in_escape, hex_q != 2'd0, phase_q == PH_HEX,
		"hex digit count outside a unicode escape")

endmodule

>>> rtl/jsu_sequencer.sv
`timescale 1ns / 1ps
// Result register holding one bundle and handing its results out one per
// output item. Depends on jsu_pkg, jsu_result_if and the macro file.
`include "json_string_unescaper_unit_macros.svh"

module jsu_sequencer (
	input  logic             clk,
	input  logic             arst_n,
	input  jsu_pkg::bundle_t bundle,
	input  logic             bundle_valid,
	output logic             bundle_ready,
	jsu_result_if.source     result
);
	import jsu_pkg::*;

	result_t [ResultSlots-1:0] res_q;
	logic [CountW-1:0]         rem_q;
	logic [SlotIdxW-1:0]       idx_q;
	logic                      take, last_take, load;
	logic [CountW-1:0]         span_chk;
	result_t                   cur;

	assign cur       = res_q[idx_q];
	assign take      = result.valid && result.ready;
	assign last_take = take && rem_q == CountW'(1);
	// A new bundle may land in the cycle the last result of the old one leaves.
	assign bundle_ready = rem_q == '0 || last_take;
	assign load         = bundle_valid && bundle_ready;
	assign span_chk     = CountW'(idx_q) + rem_q;

	assign result.valid        = rem_q != '0;
	assign result.data_byte    = cur.data_byte;
	assign result.byte_valid   = cur.byte_valid;
	assign result.string_done  = cur.string_done;
	assign result.syntax_error = cur.syntax_error;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			rem_q <= bundle.count;
			idx_q <= '0;
		end else if (take) begin
			rem_q <= rem_q - CountW'(1);
			idx_q <= idx_q + SlotIdxW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) res_q <= bundle.res;
	end

	`JSU_ASSERT_IMPL(a_span, result.valid, span_chk <= CountW'(ResultSlots),
		"result index runs past the bundle")
	`JSU_ASSERT_IMPL(a_done_last, result.valid && result.string_done, rem_q == CountW'(1),
		"string end is not the last result of its item")
	`JSU_ASSERT_IMPL(a_done_no_byte, result.valid && result.string_done, !result.byte_valid,
		"string end result carries a byte")
	`JSU_ASSERT_IMPL(a_no_overwrite, load && rem_q != '0, last_take,
		"bundle loaded over undelivered results")

endmodule

>>> rtl/json_string_unescaper_unit.sv
`timescale 1ns / 1ps
// Top level of the JSON string unescaper: decoder followed by the result
// sequencer. Depends on jsu_pkg, jsu_text_if, jsu_result_if and both submodules.
//
// Channel   Direction   Carries
// text      in          text_byte, text_ends
// result    out         data_byte, byte_valid, string_done, syntax_error
//
// A text item is accepted every cycle while no result stalls and each item gives
// at most one result. An item giving k results (up to four, from a unicode
// escape) holds the result register until all k have left; that single result
// register sets the rate. Items pass the input register, then the result register.
// Reset puts the parser in the idle state with no item or result held.
// A stall on the result side backs up into the input register, then the text side.
module json_string_unescaper_unit (
	input  logic         clk,
	input  logic         arst_n,
	jsu_text_if.sink     text,
	jsu_result_if.source result
);
	import jsu_pkg::*;

	bundle_t bundle;
	logic    bundle_valid;
	logic    bundle_ready;

	jsu_decoder u_decoder (
		.clk          (clk),
		.arst_n       (arst_n),
		.text         (text),
		.bundle       (bundle),
		.bundle_valid (bundle_valid),
		.bundle_ready (bundle_ready)
	);

	jsu_sequencer u_sequencer (
		.clk          (clk),
		.arst_n       (arst_n),
		.bundle       (bundle),
		.bundle_valid (bundle_valid),
		.bundle_ready (bundle_ready),
		.result       (result)
	);

endmodule
